// File: rtl/spd_pkg.sv
package spd_pkg;

  localparam int DIST_BITS = 22;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [1:0] MODE_WRITE     = 2'd0;
  localparam logic [1:0] MODE_WRITE_RUN = 2'd1;
  localparam logic [1:0] MODE_RUN       = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  vertex_a;
    logic [5:0]  vertex_b;
    logic [15:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic [5:0]           vertex_index;
    logic                 reachable;
    logic [DIST_BITS-1:0] distance;
    logic                 last;
  } out_word_t;

  // per-vertex entry of the vertex memory
  typedef struct packed {
    logic                 reached;
    logic                 done;
    logic [DIST_BITS-1:0] best;
  } vent_t;

  typedef struct packed {
    logic                 upd;
    logic [DIST_BITS-1:0] cand;
  } relax_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MARK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_WAIT
  } state_t;

endpackage

// File: rtl/spd_ram.sv
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/spd_relax.sv
module spd_relax
  import spd_pkg::*;
#(
  parameter int WB = 16
) (
  input  logic [DIST_BITS-1:0] base,
  input  logic [WB-1:0]        weight,
  input  vent_t                entry,
  input  logic                 skip,
  output relax_t               res
);

  logic [DIST_BITS:0] sum;

  always_comb begin
    sum = {1'b0, base} + (DIST_BITS + 1)'(weight);
    res.cand = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    res.upd = (weight != '0) && !skip && !entry.done &&
              (!entry.reached || (res.cand < entry.best));
  end

endmodule

// File: rtl/shortest_path_distances.sv
// Single-source shortest distances over an undirected weighted graph.
// Input channel (in_valid / in_stall / in_data): mode 0 writes one edge,
// mode 1 writes one edge and then runs, mode 2 runs only, mode 3 is dropped.
// Edge weight 0 removes an edge; edges touching a vertex at or above the
// vertex count are ignored. Edge writes are taken one per cycle while idle.
// A run blocks the input channel. It first initialises every vertex entry,
// then for each reached vertex runs one min scan, one mark step and one
// neighbor pass, then a final scan, then one result per vertex in index
// order on the output channel, with last set on the final one. The scans
// and neighbor passes are bound by the single read port of the vertex
// memory. After every run, and after reset, the adjacency memory is swept
// to zero, one entry a cycle, over all 2**(2*clog2(MAX_VERTICES)) entries
// (4096 by default), during which no word is accepted. Config writes are
// taken any time but only belong while idle.
// Output is held in a register; a stalled receiver simply freezes the run
// until the word is taken.
module shortest_path_distances
  import spd_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int CNTW = (CW > 7) ? CW : 7;
  localparam int IW   = (VW > 6) ? VW : 6;
  localparam int WS   = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int AW   = 2 * VW;
  localparam int ADJ_DEPTH = 1 << AW;

  state_t state, state_next;

  logic [6:0]           vcount;
  logic [5:0]           src_vertex;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_inc;
  logic [VW-1:0]        cnt_idx;
  logic                 pv;
  logic [VW-1:0]        pidx;
  logic                 found;
  logic [VW-1:0]        u;
  logic [DIST_BITS-1:0] ubest;
  logic [AW-1:0]        clr;

  logic [CNTW-1:0] vc_ext, n_ext, a_ext, b_ext;
  logic [CW-1:0]   n;
  logic [VW-1:0]   a_idx, b_idx;
  logic            in_acc, edge_wr, run_req, is_src, better;

  logic            adj_we;
  logic [AW-1:0]   adj_waddr, adj_raddr;
  logic [WS-1:0]   adj_wdata, adj_rdata;
  logic            v_we;
  logic [VW-1:0]   v_waddr, v_raddr;
  vent_t           v_wdata, v_rdata;
  relax_t          rlx;
  logic [IW-1:0]   idx_ext;

  always_comb begin
    vc_ext = CNTW'(vcount);
    if (vc_ext == '0) begin
      n_ext = CNTW'(1);
    end else if (vc_ext > CNTW'(MAX_VERTICES)) begin
      n_ext = CNTW'(MAX_VERTICES);
    end else begin
      n_ext = vc_ext;
    end
    n       = n_ext[CW-1:0];
    a_ext   = CNTW'(in_data.vertex_a);
    b_ext   = CNTW'(in_data.vertex_b);
    a_idx   = a_ext[VW-1:0];
    b_idx   = b_ext[VW-1:0];
    cnt_inc = cnt + 1'b1;
    cnt_idx = cnt[VW-1:0];
    is_src  = CNTW'(src_vertex) == CNTW'(cnt);
    idx_ext = IW'(cnt_idx);
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign edge_wr  = ((in_data.mode == MODE_WRITE) || (in_data.mode == MODE_WRITE_RUN)) &&
                    (a_ext < n_ext) && (b_ext < n_ext);
  assign run_req  = (in_data.mode == MODE_WRITE_RUN) || (in_data.mode == MODE_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= 7'd64;
      src_vertex <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:  vcount     <= cfg_data;
        CFG_SOURCE_VERTEX: src_vertex <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  spd_ram #(.WIDTH(WS), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  spd_ram #(.WIDTH($bits(vent_t)), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  spd_relax #(.WB(WS)) u_relax (
    .base   (ubest),
    .weight (adj_rdata),
    .entry  (v_rdata),
    .skip   (pidx == u),
    .res    (rlx)
  );

  assign better = v_rdata.reached && !v_rdata.done &&
                  (!found || (v_rdata.best < ubest));

  // upper-triangle storage: one write per undirected edge
  always_comb begin
    if (a_idx < b_idx) begin
      adj_waddr = {a_idx, b_idx};
    end else begin
      adj_waddr = {b_idx, a_idx};
    end
    if (u < cnt_idx) begin
      adj_raddr = {u, cnt_idx};
    end else begin
      adj_raddr = {cnt_idx, u};
    end
    adj_we     = 1'b0;
    adj_wdata  = in_data.edge_weight[WS-1:0];
    v_we       = 1'b0;
    v_waddr    = cnt_idx;
    v_wdata    = '{reached: is_src, done: 1'b0, best: '0};
    v_raddr    = cnt_idx;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr;
        adj_wdata = '0;
        if (clr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          adj_we = edge_wr;
          if (run_req) state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        v_we = 1'b1;
        if (cnt_inc == n) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == n && !pv) state_next = found ? ST_MARK : ST_OUT_RD;
      end
      ST_MARK: begin
        v_we       = 1'b1;
        v_waddr    = u;
        v_wdata    = '{reached: 1'b1, done: 1'b1, best: ubest};
        state_next = ST_RELAX;
      end
      ST_RELAX: begin
        v_we    = pv && rlx.upd;
        v_waddr = pidx;
        v_wdata = '{reached: 1'b1, done: 1'b0, best: rlx.cand};
        if (cnt == n && !pv) state_next = ST_SCAN;
      end
      ST_OUT_RD: begin
        if (!out_valid || !out_stall) state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        state_next = (cnt_inc == n) ? ST_CLEAR : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      pv    <= 1'b0;
      found <= 1'b0;
      clr   <= '0;
    end else begin
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE:  cnt <= '0;
        ST_INIT: begin
          cnt   <= (cnt_inc == n) ? '0 : cnt_inc;
          pv    <= 1'b0;
          found <= 1'b0;
        end
        ST_SCAN, ST_RELAX: begin
          if (cnt < n) begin
            cnt  <= cnt_inc;
            pv   <= 1'b1;
            pidx <= cnt_idx;
          end else begin
            pv <= 1'b0;
          end
          if (state == ST_SCAN && pv && better) begin
            found <= 1'b1;
            u     <= pidx;
            ubest <= v_rdata.best;
          end
          if (cnt == n && !pv) begin
            cnt <= '0;
          end
        end
        ST_MARK: begin
          cnt   <= '0;
          pv    <= 1'b0;
          found <= 1'b0;
        end
        ST_OUT_WAIT: begin
          cnt <= cnt_inc;
          clr <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT_WAIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT_WAIT) begin
      out_data.vertex_index <= idx_ext[5:0];
      out_data.reachable    <= v_rdata.reached;
      out_data.distance     <= v_rdata.reached ? v_rdata.best : '0;
      out_data.last         <= (cnt_inc == n);
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT_WAIT |-> !out_valid)
    else $error("output register busy when result arrives");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT_WAIT)
    else $error("result word outside output phase");

  a_no_self_relax: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELAX && v_we) |-> v_waddr != u)
    else $error("relaxation wrote the marked vertex");

  a_mark_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> (CW'(u) < n) && found)
    else $error("marked vertex out of range");

  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_acc && run_req) |=> state == ST_INIT)
    else $error("run request did not start a run");

endmodule
